[rtl/core/rcpwm_pkg.sv]
// Shared types and constants for the RC PWM pulse width decoder.
package rcpwm_pkg;

	localparam int TimerBits      = 16;
	localparam int WidthBits      = 20;
	localparam int PulseBits      = 16;
	localparam int FrameBits      = 17;
	localparam int ScaleBits      = 5;
	localparam int ChanBits       = 3;
	localparam int CfgIndexBits   = 3;
	localparam int CfgDataBits    = 17;
	localparam int DefNumChannels = 6;
	localparam int ProdBits       = TimerBits + ScaleBits;

	localparam logic [PulseBits-1:0] PulseMinRst  = PulseBits'(1000);
	localparam logic [PulseBits-1:0] PulseMaxRst  = PulseBits'(2000);
	localparam logic [FrameBits-1:0] FrameMinRst  = FrameBits'(21000);
	localparam logic [FrameBits-1:0] FrameMaxRst  = FrameBits'(24000);
	localparam logic [ScaleBits-1:0] TickScaleRst = ScaleBits'(1);
	localparam logic [WidthBits-1:0] WidthMax     = '1;

	typedef enum logic [CfgIndexBits-1:0] {
		RegPulseMin  = 3'd0,
		RegPulseMax  = 3'd1,
		RegFrameMin  = 3'd2,
		RegFrameMax  = 3'd3,
		RegTickScale = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [ChanBits-1:0]  channel;
		logic [15:0]          capture_value;
		logic                 pin_high;
	} in_req_t;

	typedef struct packed {
		logic [ChanBits-1:0]  out_channel;
		logic [WidthBits-1:0] pulse_width;
	} out_req_t;

	typedef struct packed {
		logic [PulseBits-1:0] pulse_min;
		logic [PulseBits-1:0] pulse_max;
		logic [FrameBits-1:0] frame_min;
		logic [FrameBits-1:0] frame_max;
		logic [ScaleBits-1:0] tick_scale;
	} cfg_t;

	// per-channel state as read for the current event
	typedef struct packed {
		logic                 armed;
		logic                 fall_seen;
		logic [TimerBits-1:0] rise_time;
		logic [TimerBits-1:0] last_ticks;
		logic [WidthBits-1:0] last_width;
	} chan_state_t;

	// write-back to the channel bank
	typedef struct packed {
		logic                 we;
		logic                 armed;
		logic                 fall_seen;
		logic                 rise_we;
		logic [TimerBits-1:0] rise_time;
		logic                 last_we;
		logic [TimerBits-1:0] last_ticks;
		logic [WidthBits-1:0] last_width;
	} chan_upd_t;

endpackage

[rtl/core/rcpwm_chan_bank.sv]
// Per-channel edge state registers of the RC PWM decoder.
module rcpwm_chan_bank import rcpwm_pkg::*; #(
	parameter int NUM_CHANNELS = DefNumChannels
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [ChanBits-1:0] channel,
	input  chan_upd_t           upd,
	output chan_state_t         state
);

	localparam int ChIdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic                 armed_q      [NUM_CHANNELS];
	logic                 fall_seen_q  [NUM_CHANNELS];
	logic [TimerBits-1:0] rise_time_q  [NUM_CHANNELS];
	logic [TimerBits-1:0] last_ticks_q [NUM_CHANNELS];
	logic [WidthBits-1:0] last_width_q [NUM_CHANNELS];
	logic [ChIdxW-1:0]    idx;

	assign idx = ChIdxW'({{ChIdxW{1'b0}}, channel});

	always_comb begin
		state.armed      = armed_q[idx];
		state.fall_seen  = fall_seen_q[idx];
		state.rise_time  = rise_time_q[idx];
		state.last_ticks = last_ticks_q[idx];
		state.last_width = last_width_q[idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				armed_q[i]      <= 1'b0;
				fall_seen_q[i]  <= 1'b0;
				last_ticks_q[i] <= '0;
				last_width_q[i] <= '0;
			end
		end else if (upd.we) begin
			armed_q[idx]     <= upd.armed;
			fall_seen_q[idx] <= upd.fall_seen;
			if (upd.last_we) begin
				last_ticks_q[idx] <= upd.last_ticks;
				last_width_q[idx] <= upd.last_width;
			end
		end
	end

	// rise time is only read while armed, which follows a write
	always_ff @(posedge clk) begin
		if (upd.we && upd.rise_we) begin
			rise_time_q[idx] <= upd.rise_time;
		end
	end

endmodule

[rtl/core/rcpwm_pulse_calc.sv]
// Edge decision, tick difference, window checks and width scaling.
module rcpwm_pulse_calc import rcpwm_pkg::*; #(
	parameter int NUM_CHANNELS = DefNumChannels
) (
	input  in_req_t              req,
	input  cfg_t                 cfg,
	input  chan_state_t          state,
	output chan_upd_t            upd,
	output logic                 hit,
	output logic [WidthBits-1:0] width
);

	logic                 in_range;
	logic [TimerBits-1:0] cap;
	logic [TimerBits-1:0] diff;
	logic [TimerBits:0]   sum;
	logic [ProdBits-1:0]  prod;
	logic [WidthBits-1:0] scaled;
	logic                 pulse_ok;
	logic                 frame_ok;
	logic                 do_rise;
	logic                 do_fall;

	assign in_range = {{(32 - ChanBits){1'b0}}, req.channel} < 32'(NUM_CHANNELS);
	assign cap      = req.capture_value[TimerBits-1:0];

	// wrap case subtracts one extra: cap + (max - rise)
	always_comb begin
		if (cap > state.rise_time) begin
			diff = cap - state.rise_time;
		end else if (cap < state.rise_time) begin
			diff = cap - state.rise_time - TimerBits'(1);
		end else begin
			diff = '0;
		end
	end

	assign pulse_ok = (diff > cfg.pulse_min) && (diff < cfg.pulse_max);
	assign prod     = ProdBits'(diff) * ProdBits'(cfg.tick_scale);
	assign scaled   = (prod > ProdBits'(WidthMax)) ? WidthMax : prod[WidthBits-1:0];

	assign sum      = {1'b0, cap} + {1'b0, state.last_ticks};
	assign frame_ok = (FrameBits'(sum) > cfg.frame_min) && (FrameBits'(sum) < cfg.frame_max);

	assign do_rise = in_range && !state.armed && req.pin_high;
	assign do_fall = in_range && state.armed && !req.pin_high;

	always_comb begin
		upd.we         = do_rise || do_fall;
		upd.armed      = do_rise;
		upd.fall_seen  = do_fall;
		upd.rise_we    = do_rise;
		upd.rise_time  = cap;
		upd.last_we    = do_fall && pulse_ok;
		upd.last_ticks = diff;
		upd.last_width = scaled;
	end

	assign hit   = (do_rise && state.fall_seen && frame_ok) || (do_fall && pulse_ok);
	assign width = do_fall ? scaled : state.last_width;

endmodule

[rtl/core/rc_pwm_pulse_width_decoder_unit.sv]
// Top level of the RC PWM pulse width decoder: config registers, input and result registers.
// Takes one capture event per cycle while in_stall is low and returns at most one pulse width
// per event. The event is held in the input register, and its result is loaded into the
// result register when that register is empty or draining. A rise on an idle channel arms
// it and, if a fall was seen since its last rise, may repeat the last width when rise time
// plus last tick count lies inside the frame window; a fall on an armed channel measures
// the pulse, checks it against the pulse bounds, scales it by tick_scale (saturating at 20
// bits) and reports it. Events on channels beyond NUM_CHANNELS, and rises while armed or
// falls while idle, give no result. The per-channel state is read and written back in the
// same cycle, so events on one channel may follow each other directly; input stall rises
// only while the input register is full and the result register is held by out_stall.
module rc_pwm_pulse_width_decoder_unit import rcpwm_pkg::*; #(
	parameter int NUM_CHANNELS = DefNumChannels
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CfgIndexBits-1:0] cfg_index,
	input  logic [CfgDataBits-1:0]  cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  in_req_t                 in_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output out_req_t                out_data
);

	cfg_t                 cfg_q;
	logic                 valid_s1;
	in_req_t              req_s1;
	logic                 adv;
	chan_state_t          state;
	chan_upd_t            calc_upd;
	chan_upd_t            upd;
	logic                 hit;
	logic [WidthBits-1:0] width;
	logic                 out_valid_q;
	out_req_t             out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_min  <= PulseMinRst;
			cfg_q.pulse_max  <= PulseMaxRst;
			cfg_q.frame_min  <= FrameMinRst;
			cfg_q.frame_max  <= FrameMaxRst;
			cfg_q.tick_scale <= TickScaleRst;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				RegPulseMin:  cfg_q.pulse_min  <= cfg_data[PulseBits-1:0];
				RegPulseMax:  cfg_q.pulse_max  <= cfg_data[PulseBits-1:0];
				RegFrameMin:  cfg_q.frame_min  <= cfg_data[FrameBits-1:0];
				RegFrameMax:  cfg_q.frame_max  <= cfg_data[FrameBits-1:0];
				RegTickScale: cfg_q.tick_scale <= cfg_data[ScaleBits-1:0];
				default: ;
			endcase
		end
	end

	// stage 1 moves on when the result register is empty or draining
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			req_s1 <= in_data;
		end
	end

	rcpwm_chan_bank #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_bank (
		.clk     (clk),
		.arst_n  (arst_n),
		.channel (req_s1.channel),
		.upd     (upd),
		.state   (state)
	);

	rcpwm_pulse_calc #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_calc (
		.req   (req_s1),
		.cfg   (cfg_q),
		.state (state),
		.upd   (calc_upd),
		.hit   (hit),
		.width (width)
	);

	always_comb begin
		upd    = calc_upd;
		upd.we = calc_upd.we && valid_s1 && adv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && hit) begin
			out_q.out_channel <= req_s1.channel;
			out_q.pulse_width <= width;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled without a held request");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1 && $stable(req_s1))
		else $error("stage 1 request lost while stalled");

	a_armed_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		upd.we |-> upd.armed != state.armed)
		else $error("channel update without arm change");

	a_out_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> {{(32 - ChanBits){1'b0}}, out_q.out_channel} < 32'(NUM_CHANNELS))
		else $error("result on channel out of range");

endmodule

[dv/pulse_width_checker.sv]
// Checker for the RC PWM decoder: follows the config port, predicts pulse widths, compares results.
`timescale 1ns / 100ps

module pulse_width_checker import rcpwm_pkg::*; #(
	parameter int NumChannels = DefNumChannels
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CfgIndexBits-1:0] cfg_index,
	input  logic [CfgDataBits-1:0]  cfg_data,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  in_req_t                 in_data,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  out_req_t                out_data,
	output int                      fail_count,
	output int                      pending_count
);

	cfg_t                 cfg;
	logic                 armed      [NumChannels];
	logic                 fall_seen  [NumChannels];
	logic [TimerBits-1:0] rise_time  [NumChannels];
	logic [TimerBits-1:0] last_ticks [NumChannels];
	logic [WidthBits-1:0] last_width [NumChannels];

	out_req_t expected_widths[$];
	out_req_t oldest_width;
	int       n_fail;

	task automatic decode_capture(input in_req_t req);
		int unsigned          ch;
		logic [TimerBits-1:0] cap;
		logic [TimerBits-1:0] rise;
		logic [TimerBits-1:0] diff;
		logic [TimerBits:0]   frame_sum;
		logic [ProdBits-1:0]  prod;
		out_req_t             res;
		ch  = req.channel;
		cap = req.capture_value;
		if (ch < NumChannels) begin
			if (!armed[ch] && req.pin_high) begin
				rise_time[ch] = cap;
				armed[ch]     = 1'b1;
				if (fall_seen[ch]) begin
					frame_sum = {1'b0, cap} + {1'b0, last_ticks[ch]};
					if (frame_sum > cfg.frame_min && frame_sum < cfg.frame_max) begin
						res.out_channel = req.channel;
						res.pulse_width = last_width[ch];
						expected_widths.push_back(res);
					end
					fall_seen[ch] = 1'b0;
				end
			end else if (armed[ch] && !req.pin_high) begin
				rise          = rise_time[ch];
				fall_seen[ch] = 1'b1;
				if (cap > rise)
					diff = cap - rise;
				else if (cap < rise)
					diff = cap + (16'hFFFF - rise);
				else
					diff = '0;
				if (diff > cfg.pulse_min && diff < cfg.pulse_max) begin
					prod = ProdBits'(diff) * ProdBits'(cfg.tick_scale);
					res.out_channel = req.channel;
					res.pulse_width = (prod > ProdBits'(WidthMax)) ? WidthMax : prod[WidthBits-1:0];
					last_width[ch]  = res.pulse_width;
					last_ticks[ch]  = diff;
					expected_widths.push_back(res);
				end
				armed[ch] = 1'b0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.pulse_min  = PulseMinRst;
			cfg.pulse_max  = PulseMaxRst;
			cfg.frame_min  = FrameMinRst;
			cfg.frame_max  = FrameMaxRst;
			cfg.tick_scale = TickScaleRst;
			for (int i = 0; i < NumChannels; i++) begin
				armed[i]      = 1'b0;
				fall_seen[i]  = 1'b0;
				rise_time[i]  = '0;
				last_ticks[i] = '0;
				last_width[i] = '0;
			end
			expected_widths.delete();
			n_fail = 0;
			fail_count    <= 0;
			pending_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					RegPulseMin:  cfg.pulse_min  = cfg_data[PulseBits-1:0];
					RegPulseMax:  cfg.pulse_max  = cfg_data[PulseBits-1:0];
					RegFrameMin:  cfg.frame_min  = cfg_data[FrameBits-1:0];
					RegFrameMax:  cfg.frame_max  = cfg_data[FrameBits-1:0];
					RegTickScale: cfg.tick_scale = cfg_data[ScaleBits-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_widths.size() == 0) begin
					$error("unexpected result: out_channel %0d pulse_width %0d",
						out_data.out_channel, out_data.pulse_width);
					n_fail++;
				end else begin
					oldest_width = expected_widths.pop_front();
					if (out_data.out_channel !== oldest_width.out_channel) begin
						$error("out_channel: expected %0d, got %0d",
							oldest_width.out_channel, out_data.out_channel);
						n_fail++;
					end
					if (out_data.pulse_width !== oldest_width.pulse_width) begin
						$error("pulse_width: expected %0d, got %0d",
							oldest_width.pulse_width, out_data.pulse_width);
						n_fail++;
					end
				end
			end
			if (in_valid && !in_stall)
				decode_capture(in_data);
			fail_count    <= n_fail;
			pending_count <= expected_widths.size();
		end
	end

endmodule

[dv/testbench.sv]
// Testbench top for the RC PWM decoder: clock, reset, capture stimulus, config phases, verdict.
`timescale 1ns / 100ps

module testbench;
	import rcpwm_pkg::*;

	localparam int NumChannels   = DefNumChannels;
	localparam int PhaseItems    = 203;
	localparam int NumPhases     = 8;
	localparam int DrainCycles   = 8;
	localparam int WatchdogLimit = 2000;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CfgIndexBits-1:0] cfg_index;
	logic [CfgDataBits-1:0]  cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	in_req_t                 in_data;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	out_req_t                out_data;
	int                      fail_count;
	int                      pending_count;

	int send_idle_pct;
	int recv_stall_pct = 0;
	int idle_cycles;

	// stimulus-side view of each channel, used to aim captures at the windows
	bit stim_armed [NumChannels];
	int stim_rise  [NumChannels];
	int stim_last  [NumChannels];
	int cur_pulse_min, cur_pulse_max, cur_frame_min, cur_frame_max;

	always #5 clk = ~clk;

	rc_pwm_pulse_width_decoder_unit #(.NUM_CHANNELS(NumChannels)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	pulse_width_checker #(.NumChannels(NumChannels)) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data),
		.fail_count   (fail_count),
		.pending_count(pending_count)
	);

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WatchdogLimit) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_capture(input int ch, input int cap, input bit pin);
		in_req_t req;
		req.channel       = ChanBits'(ch);
		req.capture_value = 16'(cap);
		req.pin_high      = pin;
		if (ch < NumChannels) begin
			if (!stim_armed[ch] && pin) begin
				stim_armed[ch] = 1'b1;
				stim_rise[ch]  = cap;
			end else if (stim_armed[ch] && !pin) begin
				stim_armed[ch] = 1'b0;
			end
		end
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_random_capture();
		int roll, ch, cap, diff, target;
		bit pin;
		roll = $urandom_range(0, 99);
		if (roll < 15) begin
			ch  = $urandom_range(0, 7);
			cap = $urandom_range(0, 65535);
			pin = $urandom_range(0, 1);
		end else begin
			ch = $urandom_range(0, NumChannels - 1);
			if (!stim_armed[ch]) begin
				pin = 1'b1;
				cap = $urandom_range(0, 65535);
				if (roll < 75 && cur_frame_max > cur_frame_min + 1) begin
					target = $urandom_range(cur_frame_min + 1, cur_frame_max - 1);
					if (target - stim_last[ch] >= 0 && target - stim_last[ch] <= 65535)
						cap = target - stim_last[ch];
				end
			end else begin
				pin = 1'b0;
				case (roll % 10)
					7:       diff = cur_pulse_min;
					8:       diff = cur_pulse_max;
					9:       diff = $urandom_range(0, 65534);
					default: begin
						if (cur_pulse_max > cur_pulse_min + 1)
							diff = $urandom_range(cur_pulse_min + 1, cur_pulse_max - 1);
						else
							diff = $urandom_range(0, 65534);
					end
				endcase
				// past the wrap the block measures fall + (0xFFFF - rise)
				cap = stim_rise[ch] + diff;
				if (cap > 65535)
					cap -= 65535;
				stim_last[ch] = diff;
			end
		end
		send_capture(ch, cap, pin);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CfgDataBits'(value);
		@(posedge clk);
	endtask

	task automatic write_settings(input int pmin, input int pmax, input int fmin,
		input int fmax, input int scale);
		write_reg(RegPulseMin, pmin);
		write_reg(RegPulseMax, pmax);
		write_reg(RegFrameMin, fmin);
		write_reg(RegFrameMax, fmax);
		write_reg(RegTickScale, scale);
		cfg_we <= 1'b0;
		cur_pulse_min = pmin;
		cur_pulse_max = pmax;
		cur_frame_min = fmin;
		cur_frame_max = fmax;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	initial begin
		int pmin, fmin;
		arst_n        = 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= RegPulseMin;
		cfg_data      <= '0;
		in_valid      <= 1'b0;
		in_data       <= '0;
		send_idle_pct = 0;
		cur_pulse_min = PulseMinRst;
		cur_pulse_max = PulseMaxRst;
		cur_frame_min = FrameMinRst;
		cur_frame_max = FrameMaxRst;
		for (int i = 0; i < NumChannels; i++) begin
			stim_armed[i] = 1'b0;
			stim_rise[i]  = 0;
			stim_last[i]  = 0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: arm, re-arm, measure, repeat, wrap, edge cases
		send_capture(0, 100, 1);
		send_capture(0, 200, 1);
		send_capture(0, 1600, 0);
		send_capture(0, 1700, 0);
		send_capture(0, 21000, 1);
		send_capture(0, 21000, 0);
		send_capture(1, 65000, 1);
		send_capture(1, 800, 0);
		send_capture(1, 0, 1);
		send_capture(1, 65535, 0);
		send_capture(2, 63000, 1);
		send_capture(2, 0, 0);
		send_capture(2, 22000, 1);
		send_capture(6, 1234, 1);
		send_capture(7, 65535, 0);
		send_capture(3, 65535, 1);
		send_capture(3, 1499, 0);
		send_capture(3, 0, 1);
		send_capture(3, 1001, 0);
		send_capture(4, 0, 1);
		send_capture(4, 1000, 0);
		send_capture(5, 10, 1);
		send_capture(5, 2009, 0);
		send_capture(5, 19001, 1);

		for (int p = 0; p < NumPhases; p++) begin
			if (p > 0) begin
				wait_drained();
				case (p)
					1: write_settings(0, 65535, 0, 131071, 16);
					2: write_settings(40000, 65535, 60000, 131071, 31);
					3: write_settings(1000, 2000, 21000, 24000, 0);
					4: write_settings(65535, 0, 131071, 0, 1);
					5: write_settings(500, 5000, 10000, 40000, 7);
					6: begin
						pmin = $urandom_range(0, 30000);
						fmin = $urandom_range(0, 60000);
						write_settings(pmin, pmin + $urandom_range(2, 30000), fmin,
							fmin + $urandom_range(2, 60000), $urandom_range(1, 16));
					end
					default: write_settings(100, 65534, 2, 131070, 15);
				endcase
			end
			case (p % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct <= 0;
				end
				1: begin
					send_idle_pct  = 52;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct <= 52;
				end
				default: begin
					send_idle_pct  = 13;
					recv_stall_pct <= 13;
				end
			endcase
			repeat (PhaseItems) send_random_capture();
		end

		wait_drained();
		if (fail_count == 0 && pending_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
